// File: design/rcps_pkg.sv
// Shared types and constants for the RC pulse stick calibrator.
`timescale 1ns / 1ps

package rcps_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // fixed field widths
  localparam int WIDTH_W  = 16;
  localparam int GAIN_W   = 32;
  localparam int LIMIT_W  = 15;
  localparam int POS_W    = 16;
  localparam int DIFF_W   = WIDTH_W + 1;
  localparam int PROD_W   = DIFF_W + GAIN_W;
  localparam int Q_SHIFT  = 16;
  localparam int ROUND_HALF = 32768;
  localparam int VAL_W    = PROD_W + 1 - Q_SHIFT;

  // smoothing filter
  localparam int SMOOTH_W      = 7;
  localparam int SMOOTH_KEEP   = 7;
  localparam int SMOOTH_DIV_SH = 3;
  localparam int SMOOTH_BAND   = 5;
  localparam int SMOOTH_PRESET = SMOOTH_BAND * 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);

  typedef enum logic {
    OP_CONVERT = 1'b0,
    OP_LOAD    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_CENTER    = 2'd0,
    CFG_DEVIATION = 2'd1,
    CFG_LIMIT     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    op_e                      operation;
    logic [2:0]               channel;
    logic [WIDTH_W-1:0]       raw_width;
    logic                     pulse_missing;
    logic [WIDTH_W-1:0]       cal_zero;
    logic signed [GAIN_W-1:0] cal_pos_gain;
    logic signed [GAIN_W-1:0] cal_neg_gain;
  } req_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    in_window;
  } res_t;

  typedef struct packed {
    logic [1:0]         reg_index;
    logic [WIDTH_W-1:0] wdata;
  } cfg_t;

  // stage-2 request into the smoothing filter
  typedef struct packed {
    logic                    en;
    logic [CH_W-1:0]         ch;
    logic signed [VAL_W-1:0] value;
  } smooth_req_t;

endpackage

// File: design/rcps_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
`timescale 1ns / 1ps

interface rcps_req_if;
  logic          valid;
  logic          ready;
  rcps_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rcps_res_if;
  logic          valid;
  logic          ready;
  rcps_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rcps_cfg_if;
  logic          valid;
  logic          ready;
  rcps_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/rcps_smooth.sv
// Per-channel 7/8 smoothing filter and output saturation.
`timescale 1ns / 1ps

module rcps_smooth (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  rcps_pkg::smooth_req_t                   req_i,
  input  logic [rcps_pkg::LIMIT_W-1:0]            limit_i,
  output logic signed [rcps_pkg::POS_W-1:0]       position_o
);

  localparam int MW = rcps_pkg::SMOOTH_W + 3;
  localparam int VW = rcps_pkg::VAL_W;

  logic signed [rcps_pkg::SMOOTH_W-1:0] acc_q [rcps_pkg::CHANNELS];

  logic signed [rcps_pkg::SMOOTH_W-1:0] acc_old;
  logic signed [MW-1:0]                 acc_x7;
  logic signed [MW-1:0]                 acc_kept;
  logic signed [MW-1:0]                 acc_new;
  logic signed [MW-1:0]                 acc_div;
  logic signed [rcps_pkg::SMOOTH_W-1:0] acc_d;
  logic                                 in_band;
  logic signed [VW-1:0]                 filt;
  logic signed [VW-1:0]                 lim_pos;
  logic signed [VW-1:0]                 lim_neg;
  logic signed [VW-1:0]                 sat;

  // divide by 8 truncating toward zero
  function automatic logic signed [MW-1:0] trunc_div8(input logic signed [MW-1:0] x);
    logic signed [MW-1:0] b;
    b = x[MW-1] ? x + MW'(7) : x;
    return b >>> rcps_pkg::SMOOTH_DIV_SH;
  endfunction

  assign acc_old  = acc_q[req_i.ch];
  assign acc_x7   = MW'(acc_old) * MW'(rcps_pkg::SMOOTH_KEEP);
  assign acc_kept = trunc_div8(acc_x7);
  assign in_band  = (req_i.value >= -VW'(rcps_pkg::SMOOTH_BAND)) &&
                    (req_i.value <=  VW'(rcps_pkg::SMOOTH_BAND));
  assign acc_new  = acc_kept + MW'(req_i.value[MW-1:0]);
  assign acc_div  = trunc_div8(acc_new);

  always_comb begin
    if (in_band) begin
      acc_d = acc_new[rcps_pkg::SMOOTH_W-1:0];
      filt  = VW'(acc_div);
    end else begin
      acc_d = req_i.value[VW-1] ? -rcps_pkg::SMOOTH_W'(rcps_pkg::SMOOTH_PRESET)
                                :  rcps_pkg::SMOOTH_W'(rcps_pkg::SMOOTH_PRESET);
      filt  = req_i.value;
    end
  end

  assign lim_pos = VW'($signed({1'b0, limit_i}));
  assign lim_neg = -lim_pos;

  always_comb begin
    if (filt < lim_neg) begin
      sat = lim_neg;
    end else if (filt > lim_pos) begin
      sat = lim_pos;
    end else begin
      sat = filt;
    end
  end

  assign position_o = sat[rcps_pkg::POS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rcps_pkg::CHANNELS; i++) begin
        acc_q[i] <= '0;
      end
    end else if (req_i.en) begin
      acc_q[req_i.ch] <= acc_d;
    end
  end

endmodule

// File: design/rc_pulse_stick_calibrate.sv
// Top level of the RC pulse stick calibrator.
`timescale 1ns / 1ps

// Converts RC channel pulse widths to stick positions. A request with
// operation load stores the zero width and the two Q16 gains of a channel;
// load a channel before converting on it. A convert request yields exactly
// one result: position 0 / in_window 0 when the pulse is flagged missing or
// lies outside center +/- (deviation + deviation/8), otherwise the width
// minus the channel zero, times the positive or negative gain, rounded and
// shifted down 16, smoothed per channel when within +/-5, and saturated to
// +/- stick_limit. Loads yield no result. Throughput is one request per
// cycle while no stage is stalled; a convert passes three registers: an
// input register, a register after the gain multiplier, and the result
// register fed by rounding, the filter and saturation. The filter state is
// read and written in the last stage, so back-to-back samples on one channel
// chain correctly. The result register frees the input side while a result
// waits; the stages stall only when full. Configuration must be written
// through the cfg port while no request is in flight; the block itself does
// not enforce this. The cfg port is always ready.
module rc_pulse_stick_calibrate (
  input  logic       clk_i,
  input  logic       rst_ni,
  rcps_req_if.sink   req_i,
  rcps_res_if.source res_o,
  rcps_cfg_if.sink   cfg_i
);

  localparam int WW = rcps_pkg::WIDTH_W;
  localparam int BW = WW + 3;

  // configuration
  logic [WW-1:0]                    center_q;
  logic [WW-1:0]                    deviation_q;
  logic [rcps_pkg::LIMIT_W-1:0]     limit_q;

  // calibration tables, no reset
  logic [WW-1:0]                    zero_q     [rcps_pkg::CHANNELS];
  logic signed [rcps_pkg::GAIN_W-1:0] pos_gain_q [rcps_pkg::CHANNELS];
  logic signed [rcps_pkg::GAIN_W-1:0] neg_gain_q [rcps_pkg::CHANNELS];

  // stage 1: input register
  logic                             s1_valid_q;
  rcps_pkg::req_t                   s1_q;

  // stage 2: product register
  logic                             s2_valid_q;
  logic                             s2_ok_q;
  logic [rcps_pkg::CH_W-1:0]        s2_ch_q;
  logic signed [rcps_pkg::PROD_W-1:0] s2_prod_q;

  // result register
  logic                             out_valid_q;
  rcps_pkg::res_t                   out_q;

  logic                             out_free;
  logic                             s2_move;
  logic                             s2_free;
  logic                             s1_is_load;
  logic                             s1_retire;
  logic                             s1_conv_move;

  logic [rcps_pkg::CH_W-1:0]        s1_idx;
  logic                             s1_ch_ok;
  logic [WW:0]                      dev_ext;
  logic signed [BW-1:0]             win_lo;
  logic signed [BW-1:0]             win_hi;
  logic signed [BW-1:0]             raw_ext;
  logic                             s1_in_win;
  logic signed [rcps_pkg::DIFF_W-1:0] diff;
  logic signed [rcps_pkg::GAIN_W-1:0] gain;
  logic signed [rcps_pkg::PROD_W-1:0] prod;

  logic signed [rcps_pkg::PROD_W:0] rounded;
  rcps_pkg::smooth_req_t            sm_req;
  logic signed [rcps_pkg::POS_W-1:0] sm_pos;

  // flow control
  assign out_free     = !out_valid_q || res_o.ready;
  assign s2_move      = s2_valid_q && out_free;
  assign s2_free      = !s2_valid_q || out_free;
  assign s1_is_load   = (s1_q.operation == rcps_pkg::OP_LOAD);
  assign s1_retire    = s1_valid_q && (s1_is_load || s2_free);
  assign s1_conv_move = s1_retire && !s1_is_load;
  assign req_i.ready  = !s1_valid_q || s1_retire;
  assign cfg_i.ready  = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q    <= '0;
      deviation_q <= '0;
      limit_q     <= rcps_pkg::LIMIT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_index)
        rcps_pkg::CFG_CENTER:    center_q    <= cfg_i.data.wdata;
        rcps_pkg::CFG_DEVIATION: deviation_q <= cfg_i.data.wdata;
        rcps_pkg::CFG_LIMIT:     limit_q     <= cfg_i.data.wdata[rcps_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: window check, zero subtract, gain multiply
  assign s1_idx   = s1_q.channel[rcps_pkg::CH_W-1:0];
  assign s1_ch_ok = (32'(s1_q.channel) < rcps_pkg::CHANNELS);

  assign dev_ext = {1'b0, deviation_q} + (WW+1)'(deviation_q >> 3);
  assign win_lo  = $signed(BW'(center_q)) - $signed(BW'(dev_ext));
  assign win_hi  = $signed(BW'(center_q)) + $signed(BW'(dev_ext));
  assign raw_ext = $signed(BW'(s1_q.raw_width));

  assign s1_in_win = s1_ch_ok && !s1_q.pulse_missing &&
                     (raw_ext >= win_lo) && (raw_ext <= win_hi);

  assign diff = $signed({1'b0, s1_q.raw_width}) - $signed({1'b0, zero_q[s1_idx]});
  assign gain = diff[rcps_pkg::DIFF_W-1] ? neg_gain_q[s1_idx] : pos_gain_q[s1_idx];
  assign prod = rcps_pkg::PROD_W'(diff) * rcps_pkg::PROD_W'(gain);

  always_ff @(posedge clk_i) begin
    if (s1_retire && s1_is_load && s1_ch_ok) begin
      zero_q[s1_idx]     <= s1_q.cal_zero;
      pos_gain_q[s1_idx] <= s1_q.cal_pos_gain;
      neg_gain_q[s1_idx] <= s1_q.cal_neg_gain;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_q <= req_i.data;
    end
    if (s1_conv_move) begin
      s2_ok_q   <= s1_in_win;
      s2_ch_q   <= s1_idx;
      s2_prod_q <= prod;
    end
    if (s2_move) begin
      out_q.position  <= s2_ok_q ? sm_pos : '0;
      out_q.in_window <= s2_ok_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (s1_conv_move) begin
        s2_valid_q <= 1'b1;
      end else if (s2_move) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_move) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // stage 2: round to nearest (floor of p + 1/2), filter, saturate
  assign rounded = (rcps_pkg::PROD_W+1)'(s2_prod_q) +
                   (rcps_pkg::PROD_W+1)'(rcps_pkg::ROUND_HALF);

  assign sm_req.en    = s2_move && s2_ok_q;
  assign sm_req.ch    = s2_ch_q;
  assign sm_req.value = rounded[rcps_pkg::PROD_W:rcps_pkg::Q_SHIFT];

  rcps_smooth u_smooth (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (sm_req),
    .limit_i    (limit_q),
    .position_o (sm_pos)
  );

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // a rejected sample always reports position zero
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.in_window) |-> (out_q.position == '0))
    else $error("rejected sample with nonzero position");

  // position never exceeds the stick limit
  a_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |->
      (($signed(17'(out_q.position)) <=  $signed({2'b0, limit_q})) &&
       ($signed(17'(out_q.position)) >= -$signed({2'b0, limit_q}))))
    else $error("position beyond stick limit");

  // input side only stalls when stage 1 holds a convert, stage 2 is full and the result register cannot take it
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (s1_valid_q && !s1_is_load && s2_valid_q && !out_free))
    else $error("input stalled with room in the pipeline");

  // a stalled product stays in stage 2
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !out_free) |=> (s2_valid_q && $stable(s2_prod_q)))
    else $error("stage 2 product lost under stall");

endmodule

// File: bench/rcps_stick_checker.sv
// Checker for the RC pulse stick calibrator: predicts each result and compares.
`timescale 1ns / 1ps

module rcps_stick_checker (
  input  logic clk_i,
  input  logic rst_ni,
  rcps_req_if  req_i,
  rcps_res_if  res_i,
  rcps_cfg_if  cfg_i,
  output int   mismatch_count_o,
  output int   results_due_o
);
  import rcps_pkg::*;

  // shadow of the block's registers and per-channel tables
  int                 center_q;
  int                 deviation_q;
  int                 limit_q;
  int                 zero_tab     [CHANNELS];
  longint             pos_gain_tab [CHANNELS];
  longint             neg_gain_tab [CHANNELS];
  int                 smooth_acc   [CHANNELS];

  res_t               expected_sticks [$];

  // Stick position for one convert request; updates the channel's filter.
  function automatic res_t predict_stick(req_t r);
    longint span, lo, hi, raw, diff, prod, val, lim;
    int     ch;
    int     acc;
    res_t   res;
    ch   = int'(r.channel);
    raw  = longint'(r.raw_width);
    span = longint'(deviation_q + deviation_q / 8);
    lo   = longint'(center_q) - span;
    hi   = longint'(center_q) + span;
    res  = '0;
    if (ch >= CHANNELS || r.pulse_missing || raw < lo || raw > hi) begin
      return res;
    end
    diff = raw - longint'(zero_tab[ch]);
    prod = diff * ((diff >= 0) ? pos_gain_tab[ch] : neg_gain_tab[ch]);
    val  = (prod + ROUND_HALF) >>> Q_SHIFT;
    if (val >= -SMOOTH_BAND && val <= SMOOTH_BAND) begin
      // C-style truncating division on both steps
      acc = smooth_acc[ch] * SMOOTH_KEEP / 8 + int'(val);
      smooth_acc[ch] = acc;
      val = longint'(acc / 8);
    end else begin
      smooth_acc[ch] = (val > 0) ? SMOOTH_PRESET : -SMOOTH_PRESET;
    end
    lim = longint'(limit_q);
    if (val < -lim) begin
      val = -lim;
    end else if (val > lim) begin
      val = lim;
    end
    res.position  = val[POS_W-1:0];
    res.in_window = 1'b1;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    if (!rst_ni) begin
      center_q    = 0;
      deviation_q = 0;
      limit_q     = int'(LIMIT_RESET);
      for (int i = 0; i < CHANNELS; i++) begin
        zero_tab[i]     = 0;
        pos_gain_tab[i] = 0;
        neg_gain_tab[i] = 0;
        smooth_acc[i]   = 0;
      end
      expected_sticks.delete();
      mismatch_count_o = 0;
      results_due_o    = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_idx_e'(cfg_i.data.reg_index))
          CFG_CENTER:    center_q    = int'(cfg_i.data.wdata);
          CFG_DEVIATION: deviation_q = int'(cfg_i.data.wdata);
          CFG_LIMIT:     limit_q     = int'(cfg_i.data.wdata[LIMIT_W-1:0]);
          default: ;
        endcase
      end

      // results first: a request taken at this edge cannot answer at it
      if (res_i.valid && res_i.ready) begin
        got = res_i.data;
        if (expected_sticks.size() == 0) begin
          $display("%0t: unexpected result, expected none, got position %0d in_window %0b",
                   $time, $signed(got.position), got.in_window);
          mismatch_count_o++;
        end else begin
          want = expected_sticks.pop_front();
          if (got.position !== want.position) begin
            $display("%0t: position mismatch, expected %0d, got %0d",
                     $time, $signed(want.position), $signed(got.position));
            mismatch_count_o++;
          end
          if (got.in_window !== want.in_window) begin
            $display("%0t: in_window mismatch, expected %0b, got %0b",
                     $time, want.in_window, got.in_window);
            mismatch_count_o++;
          end
        end
      end

      if (req_i.valid && req_i.ready) begin
        if (req_i.data.operation == OP_LOAD) begin
          if (req_i.data.channel < CHANNELS) begin
            zero_tab[req_i.data.channel]     = int'(req_i.data.cal_zero);
            pos_gain_tab[req_i.data.channel] = longint'(req_i.data.cal_pos_gain);
            neg_gain_tab[req_i.data.channel] = longint'(req_i.data.cal_neg_gain);
          end
        end else begin
          expected_sticks.push_back(predict_stick(req_i.data));
        end
      end

      results_due_o = expected_sticks.size();
    end
  end

endmodule

// File: bench/tb_top.sv
// Top of the RC pulse stick calibrator testbench: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top;
  import rcps_pkg::*;

  // pipeline is three stages deep; a few spare cycles cover trailing loads
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS   = 100;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // idle percentages of the current phase
  int send_idle_pct = 0;
  int stall_pct     = 0;

  int mismatch_count;
  int results_due;

  // what the stimulus side knows, used only to aim pulse widths
  int center_set;
  int deviation_set;
  int zero_shadow [CHANNELS];

  rcps_req_if req_bus ();
  rcps_res_if res_bus ();
  rcps_cfg_if cfg_bus ();

  rc_pulse_stick_calibrate u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  rcps_stick_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_bus),
    .res_i            (res_bus),
    .cfg_i            (cfg_bus),
    .mismatch_count_o (mismatch_count),
    .results_due_o    (results_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    res_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  // hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("rc_pulse_stick_calibrate test failed");
    $finish;
  end

  function automatic int clip_width(int v);
    if (v < 0) begin
      return 0;
    end
    if (v > 65535) begin
      return 65535;
    end
    return v;
  endfunction

  // Q16 gains: often near 1.0 so small values reach the filter,
  // some moderate, some with every bit random
  function automatic logic [31:0] pick_gain();
    int          pick;
    logic [31:0] g;
    pick = $urandom_range(99);
    if (pick < 15) begin
      g = $urandom;
    end else if (pick < 60) begin
      g = $urandom_range(140000, 30000);
    end else begin
      g = $urandom_range(1 << 20);
    end
    if ($urandom_range(1)) begin
      g = -g;
    end
    return g;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request
  // is taken with valid still high, so back-to-back requests never drop it.
  task automatic push_request(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.data  <= r;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_channel(input int ch, input int zero,
                              input logic [31:0] pos_gain, input logic [31:0] neg_gain);
    req_t r;
    r.operation     = OP_LOAD;
    r.channel       = 3'(ch);
    r.raw_width     = 16'($urandom);
    r.pulse_missing = 1'($urandom_range(1));
    r.cal_zero      = 16'(zero);
    r.cal_pos_gain  = pos_gain;
    r.cal_neg_gain  = neg_gain;
    zero_shadow[ch] = zero;
    push_request(r);
  endtask

  // calibration fields ride along with random content; the block ignores them
  task automatic convert(input int ch, input int raw, input bit missing);
    req_t r;
    r.operation     = OP_CONVERT;
    r.channel       = 3'(ch);
    r.raw_width     = 16'(raw);
    r.pulse_missing = missing;
    r.cal_zero      = 16'($urandom);
    r.cal_pos_gain  = $urandom;
    r.cal_neg_gain  = $urandom;
    push_request(r);
  endtask

  // sender holds off until the last expected result is out; returns at a
  // later falling edge than the one it was called at
  task automatic await_results();
    req_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (results_due != 0) @(negedge clk_i);
  endtask

  // Registers change only with the pipe empty. Loads leave nothing to wait
  // on, so a fixed settle follows the drain. The limit goes out with a
  // random top bit, which the block must drop.
  task automatic apply_settings(input int center, input int deviation, input int limit);
    cfg_idx_e    idx [3];
    logic [15:0] val [3];
    await_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    idx = '{CFG_CENTER, CFG_DEVIATION, CFG_LIMIT};
    val = '{16'(center), 16'(deviation), {1'($urandom_range(1)), 15'(limit)}};
    cfg_bus.valid <= 1'b1;
    foreach (idx[k]) begin
      cfg_bus.data <= '{reg_index: idx[k], wdata: val[k]};
      @(posedge clk_i);
      while (!cfg_bus.ready) @(posedge clk_i);
      @(negedge clk_i);
    end
    cfg_bus.valid <= 1'b0;
    center_set    = center;
    deviation_set = deviation;
  endtask

  // Mostly well-formed converts aimed at the window or at the channel zero
  // (small values exercise the filter); some loads, edges, misses and noise.
  task automatic random_request();
    int kind, pick, span, lo, hi, ch, raw;
    span = deviation_set + deviation_set / 8;
    lo   = center_set - span;
    hi   = center_set + span;
    ch   = $urandom_range(CHANNELS - 1);
    kind = $urandom_range(99);
    if (kind < 10) begin
      if ($urandom_range(1)) begin
        raw = $urandom_range(65535);
      end else begin
        raw = clip_width(center_set + int'($urandom_range(2 * span)) - span);
      end
      load_channel(ch, raw, pick_gain(), pick_gain());
    end else begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        raw = clip_width(zero_shadow[ch] + int'($urandom_range(16)) - 8);
      end else if (pick < 75) begin
        raw = $urandom_range(clip_width(hi), clip_width(lo));
      end else if (pick < 90) begin
        raw = $urandom_range(65535);
      end else if (lo > 0 && $urandom_range(1)) begin
        raw = lo - 1;
      end else if (hi < 65535) begin
        raw = hi + 1;
      end else begin
        raw = $urandom_range(65535);
      end
      convert(ch, raw, $urandom_range(99) < 8);
    end
  endtask

  // one idling phase; halfway through the sender drains the block
  task automatic run_phase(input int center, input int deviation, input int limit,
                           input int send_pct, input int stall_in);
    apply_settings(center, deviation, limit);
    send_idle_pct = send_pct;
    stall_pct     = stall_in;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == PHASE_ITEMS / 2) begin
        await_results();
      end
      random_request();
    end
  endtask

  initial begin
    req_bus.valid = 1'b0;
    req_bus.data  = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data  = '0;
    res_bus.ready = 1'b0;
    foreach (zero_shadow[i]) zero_shadow[i] = 0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // window 938..2062, limit 1000
    apply_settings(1500, 500, 1000);

    // every channel gets calibration before any convert touches it
    load_channel(0, 1500, 32'd131072, 32'd131072);     // gain 2.0
    load_channel(1, 1500, 32'd65536, 32'd65536);       // gain 1.0, filter work
    load_channel(2, 1500, 32'd32768, 32'd32768);       // gain 0.5, rounding halves
    load_channel(3, 1000, 32'h7FFF_FFFF, 32'h8000_0000); // extreme gains
    load_channel(4, 2062, -32'sd65536, -32'sd131072);  // negative gains
    load_channel(5, 0, 32'd1, 32'd1);
    load_channel(6, 65535, 32'd65536, 32'h8000_0000);
    load_channel(7, 938, 32'd40000, 32'd70000);

    // window edges, just outside, and a flagged miss inside
    convert(0, 938, 1'b0);
    convert(0, 2062, 1'b0);
    convert(0, 937, 1'b0);
    convert(0, 2063, 1'b0);
    convert(0, 1700, 1'b1);
    // filter: accumulate, preset to +40 and -40 by large values, decay
    convert(1, 1503, 1'b0);
    convert(1, 1503, 1'b0);
    convert(1, 1505, 1'b0);
    convert(1, 1600, 1'b0);
    convert(1, 1501, 1'b0);
    convert(1, 1300, 1'b0);
    convert(1, 1495, 1'b0);
    convert(1, 1500, 1'b0);
    // exact half rounds up on both sides of zero
    convert(2, 1501, 1'b0);
    convert(2, 1499, 1'b0);
    // full-width products far past the limit
    convert(3, 2062, 1'b0);
    convert(3, 938, 1'b0);
    convert(4, 1000, 1'b0);

    // zero stick limit forces every position to 0
    apply_settings(1500, 500, 0);
    convert(0, 1700, 1'b0);
    convert(1, 1400, 1'b0);
    convert(1, 1502, 1'b0);

    // window covering every width: both width extremes
    apply_settings(32768, 65535, 32767);
    convert(5, 0, 1'b0);
    convert(5, 65535, 1'b0);
    convert(6, 0, 1'b0);
    convert(6, 65535, 1'b0);

    run_phase(32768, 65535, 32767, 0, 0);
    run_phase(1500, 500, $urandom_range(2000, 1), 84, 0);
    run_phase($urandom_range(65535), $urandom_range(65535), $urandom_range(32767), 0, 84);
    run_phase(0, 8, 1, 21, 21);

    await_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("rc_pulse_stick_calibrate test passed");
    end else begin
      $display("rc_pulse_stick_calibrate test failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/rcps_pkg.sv
design/rcps_if.sv
design/rcps_smooth.sv
design/rc_pulse_stick_calibrate.sv
bench/rcps_stick_checker.sv
bench/tb_top.sv
